/* rtl/stk_pkg.sv */
// Shared constants, byte codes and character-class functions for the source tokenizer.
// Used by stk_core, source_tokenizer and stk_checker; depends on nothing else.
package stk_pkg;

	localparam int OFFSET_BITS_DEF = 20;
	localparam int COLUMN_BITS_DEF = 16;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_BTICK  = 8'h60;

	// Where the pending token starts after a byte.
	typedef enum logic [1:0] {
		NS_KEEP,
		NS_HERE,
		NS_AFTER
	} next_start_t;

	function automatic logic is_op(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2F, 8'h3A,
			8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h7C, 8'h7E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return is_digit(c) || (c == CH_DOT);
	endfunction

	function automatic logic is_word_byte(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER) || (c == CH_BTICK);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h2C, CH_BSLASH, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/stk_core.sv */
// Tokenizer state registers and the per-byte decision logic: up to two result words per byte.
// Depends on stk_pkg (byte codes, class functions, next_start_t).
module stk_core #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int COLUMN_BITS = stk_pkg::COLUMN_BITS_DEF,
	parameter int TDATA_W     = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         ch,
	input  logic               eoc,
	input  logic               commit,
	output logic [1:0]         res_count,
	output logic [TDATA_W-1:0] res0,
	output logic [TDATA_W-1:0] res1
);

	localparam int OB = OFFSET_BITS;
	localparam int CB = COLUMN_BITS;
	localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
	localparam logic [CB-1:0] COL_MAX = {CB{1'b1}};

	logic          in_comment_q, in_string_q, esc_q, all_num_q;
	logic [7:0]    prev_q;
	logic [OB-1:0] ws_q, idx_q, line_q;
	logic [CB-1:0] col_q;

	logic          in_comment_d, in_string_d, esc_d, all_num_d;
	logic [OB-1:0] ws_d, idx_d, line_d;
	logic [CB-1:0] col_d;

	stk_pkg::next_start_t ns;
	logic          pending, split;
	logic          p0_en, p1_en, p2_en;
	logic [OB:0]   p0_len, p2_len;
	logic [OB-1:0] p2_line;
	logic [CB-1:0] p2_col;
	logic [TDATA_W-1:0] w0, w1, w2;

	always_comb begin
		pending      = ws_q < idx_q;
		in_comment_d = in_comment_q;
		in_string_d  = in_string_q;
		esc_d        = esc_q;
		ns           = stk_pkg::NS_KEEP;
		p0_en        = 1'b0;
		p0_len       = {1'b0, idx_q} - {1'b0, ws_q};
		p1_en        = 1'b0;
		split = pending && ((stk_pkg::is_op(prev_q) && !stk_pkg::is_op(ch)) ||
			(stk_pkg::is_num(prev_q) && !stk_pkg::is_num(ch)) ||
			(stk_pkg::is_word_byte(prev_q) && !stk_pkg::is_word_byte(ch) &&
			(!all_num_q || ch != stk_pkg::CH_DOT)));

		if (in_comment_q) begin
			if (ch == stk_pkg::CH_LF)
				in_comment_d = 1'b0;
			ns = stk_pkg::NS_AFTER;
		end else if (in_string_q) begin
			if (esc_q) begin
				esc_d = 1'b0;
			end else if (ch == stk_pkg::CH_QUOTE) begin
				// close the string: quote belongs to the token
				p0_en       = 1'b1;
				p0_len      = {1'b0, idx_q} - {1'b0, ws_q} + (OB+1)'(1);
				in_string_d = 1'b0;
				ns          = stk_pkg::NS_AFTER;
			end else if (ch == stk_pkg::CH_BSLASH) begin
				esc_d = 1'b1;
			end
		end else if (ch == stk_pkg::CH_HASH) begin
			p0_en        = pending;
			in_comment_d = 1'b1;
			ns           = stk_pkg::NS_AFTER;
		end else if (stk_pkg::is_space(ch)) begin
			p0_en = pending;
			ns    = stk_pkg::NS_AFTER;
		end else if (stk_pkg::is_punct(ch)) begin
			p0_en = pending;
			p1_en = 1'b1;
			ns    = stk_pkg::NS_AFTER;
		end else if (ch == stk_pkg::CH_QUOTE) begin
			p0_en       = pending;
			in_string_d = 1'b1;
			ns          = stk_pkg::NS_HERE;
		end else if (split) begin
			p0_en = 1'b1;
			ns    = stk_pkg::NS_HERE;
		end

		idx_d = (idx_q == OFF_MAX) ? OFF_MAX : idx_q + OB'(1);
		unique case (ns)
			stk_pkg::NS_AFTER: begin
				ws_d      = idx_d;
				all_num_d = 1'b1;
			end
			stk_pkg::NS_HERE: begin
				ws_d      = idx_q;
				all_num_d = stk_pkg::is_num(ch);
			end
			default: begin
				ws_d      = ws_q;
				all_num_d = all_num_q && stk_pkg::is_num(ch);
			end
		endcase

		if (ch == stk_pkg::CH_LF) begin
			line_d = (line_q == OFF_MAX) ? OFF_MAX : line_q + OB'(1);
			col_d  = CB'(1);
		end else begin
			line_d = line_q;
			col_d  = (col_q == COL_MAX) ? COL_MAX : col_q + CB'(1);
		end

		// flush of the pending token after the last byte
		p2_en   = eoc && (ws_d < idx_d) && !in_comment_d;
		p2_len  = {1'b0, idx_d} - {1'b0, ws_d};
		p2_line = line_d;
		p2_col  = col_d;

		w0 = TDATA_W'({col_q, line_q, p0_len, ws_q});
		w1 = TDATA_W'({col_q, line_q, (OB+1)'(1), idx_q});
		w2 = TDATA_W'({p2_col, p2_line, p2_len, ws_d});

		res_count = 2'(p0_en) + 2'(p1_en) + 2'(p2_en);
		res0 = p0_en ? w0 : (p1_en ? w1 : w2);
		res1 = (p0_en && p1_en) ? w1 : w2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			in_string_q  <= 1'b0;
			esc_q        <= 1'b0;
			prev_q       <= stk_pkg::CH_LF;
			ws_q         <= '0;
			all_num_q    <= 1'b1;
			idx_q        <= '0;
			line_q       <= OB'(1);
			col_q        <= CB'(1);
		end else if (commit) begin
			if (eoc) begin
				// text done: start over at offset 0, line 1, column 1
				in_comment_q <= 1'b0;
				in_string_q  <= 1'b0;
				esc_q        <= 1'b0;
				prev_q       <= stk_pkg::CH_LF;
				ws_q         <= '0;
				all_num_q    <= 1'b1;
				idx_q        <= '0;
				line_q       <= OB'(1);
				col_q        <= CB'(1);
			end else begin
				in_comment_q <= in_comment_d;
				in_string_q  <= in_string_d;
				esc_q        <= esc_d;
				prev_q       <= ch;
				ws_q         <= ws_d;
				all_num_q    <= all_num_d;
				idx_q        <= idx_d;
				line_q       <= line_d;
				col_q        <= col_d;
			end
		end
	end

endmodule

/* rtl/source_tokenizer.sv */
// Flow: a byte accepted into the input stage has its first token word loaded into the output register once it is free.
// Throughput: one byte per cycle while the output is not stalled; a byte that closes two tokens holds the input stage
// until its second word is loaded, one per output word, since the single output register takes one word a cycle.
// Reset: arst_n clears the input stage, output register and tokenizer state at once
// (offset 0, line 1, column 1, no pending token).
// Top level: input register, stk_core decision logic, output register. Depends on stk_pkg.
module source_tokenizer #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int COLUMN_BITS = stk_pkg::COLUMN_BITS_DEF,
	localparam int RAW_W      = 3 * OFFSET_BITS + 1 + COLUMN_BITS,
	localparam int TDATA_W    = ((RAW_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] ch
	input  logic               s_axis_tlast,  // end_of_code
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // token_start, token_length, line_number,
	                                          // column_number, zero pad
	output logic               m_axis_tlast   // last_of_run
);

	logic       valid_s1, phase_q;
	logic [7:0] ch_s1;
	logic       eoc_s1;
	logic [1:0] res_count;
	logic [TDATA_W-1:0] res0, res1;
	logic       out_free, emit, done, is_last;
	logic       out_valid_q, out_last_q;
	logic [TDATA_W-1:0] out_data_q;

	stk_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.TDATA_W    (TDATA_W)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch_s1),
		.eoc      (eoc_s1),
		.commit   (done),
		.res_count(res_count),
		.res0     (res0),
		.res1     (res1)
	);

	always_comb begin
		out_free = !out_valid_q || m_axis_tready;
		is_last  = (res_count == 2'd1) || phase_q;
		emit     = valid_s1 && (res_count != 2'd0) && out_free;
		done     = valid_s1 && ((res_count == 2'd0) || (emit && is_last));
		s_axis_tready = !valid_s1 || done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (done)
				phase_q <= 1'b0;
			else if (emit)
				phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1  <= s_axis_tdata;
			eoc_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= phase_q ? res1 : res0;
			out_last_q <= is_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/stk_checker.sv */
// Port-level checks for source_tokenizer, bound to every instance of it.
// Depends on stk_pkg for default widths only.
module stk_checker #(
	parameter int OFFSET_BITS = stk_pkg::OFFSET_BITS_DEF,
	parameter int COLUMN_BITS = stk_pkg::COLUMN_BITS_DEF,
	localparam int RAW_W      = 3 * OFFSET_BITS + 1 + COLUMN_BITS,
	localparam int TDATA_W    = ((RAW_W + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic [7:0]         s_axis_tdata,
	input logic               s_axis_tlast,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tlast
);

	localparam int OB = OFFSET_BITS;
	localparam int CB = COLUMN_BITS;

	logic [OB:0]   f_len;
	logic [OB-1:0] f_line;
	logic [CB-1:0] f_col;

	assign f_len  = m_axis_tdata[2*OB:OB];
	assign f_line = m_axis_tdata[3*OB:2*OB+1];
	assign f_col  = m_axis_tdata[3*OB+CB:3*OB+1];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> f_len != '0)
		else $error("token of zero length");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (f_line != '0) && (f_col != '0))
		else $error("line or column is zero");

	a_no_input_ready_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tvalid && !m_axis_tvalid ##1 !m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with nothing in flight");

endmodule

bind source_tokenizer stk_checker #(
	.OFFSET_BITS(OFFSET_BITS),
	.COLUMN_BITS(COLUMN_BITS)
) u_stk_checker (.*);
